FILE: hdl/aigh_pkg.sv
// Package for the AIG structural hashing unit: outcome codes, constants and
// the command and status structs between controller and datapath.
// Depends on nothing; the top, aigh_ctrl and aigh_dpath use it by scoped names.
package aigh_pkg;

  // Default configuration of the unit.
  localparam int LIT_BITS_DEF    = 16;
  localparam int TABLE_DEPTH_DEF = 1024;

  // Clears the complement bit of a literal.
  localparam logic [31:0] LIT_ODD_CLEAR = 32'hFFFF_FFFE;

  // Outcome codes on the result channel.
  localparam int OUTCOME_W = 3;
  localparam logic [OUTCOME_W-1:0] OUT_FOLDED    = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FOUND     = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_NEW_GATE  = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_NEW_INPUT = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_FULL      = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;   // write one cleared row during the clearing pass
    logic take;       // capture an incoming request
    logic step;       // move to the next probe slot
    logic take_hit;   // load the stored literal of a matching row
    logic take_miss;  // allocate a new gate or report full
    logic emit;       // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;   // the clearing pass is at its last row
    logic direct;     // the incoming request needs no table lookup
    logic hit;        // the probed row holds the key
    logic empty;      // the probed row was never filled
    logic probe_last; // every slot of the table has been probed
  } status_t;

endpackage

FILE: hdl/aig_and_node_hash_consing_unit.sv
// Requests are taken one at a time; inputs and folded ANDs need no table lookup,
// while other ANDs probe the open-addressed table in a read-then-compare loop
// on the single-port table memory.
// Reset: a clearing pass marks every table row empty, with in_stall held high;
// the gate count and last literal start at zero.
module aig_and_node_hash_consing_unit #(
  parameter int LIT_BITS    = aigh_pkg::LIT_BITS_DEF,
  parameter int TABLE_DEPTH = aigh_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [LIT_BITS-1:0]            in_lit_a,
  input  logic [LIT_BITS-1:0]            in_lit_b,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [LIT_BITS-1:0]            out_result_literal,
  output logic [aigh_pkg::OUTCOME_W-1:0] out_outcome
);

  aigh_pkg::cmd_t    cmd;
  aigh_pkg::status_t sts;

  // Sequencing of each request.
  aigh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Folding, hashing, table and result registers.
  aigh_dpath #(
    .LIT_BITS    (LIT_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_opcode          (in_opcode),
    .in_lit_a           (in_lit_a),
    .in_lit_b           (in_lit_b),
    .out_result_literal (out_result_literal),
    .out_outcome        (out_outcome),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

FILE: hdl/aigh_ram.sv
// Generic single-port RAM with a registered read.
// Depends on nothing.
module aigh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // The addressed word is read every cycle and written when we is high; a read during a write returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/aigh_ctrl.sv
// Controller for the AIG structural hashing unit: clearing pass, request
// acceptance, probe sequencing and the output valid flag.
// Depends on aigh_pkg.
module aigh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  aigh_pkg::status_t sts,
  output aigh_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_busy;

  assign out_busy = out_valid_r && out_stall;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = sts.direct ? S_RESP : S_PROBE;
        end
      end
      S_PROBE: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = S_RESP;
        end else if (sts.empty || sts.probe_last) begin
          cmd.take_miss = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_RESP: begin
        if (!out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Output valid flag: set when a result is loaded, dropped after its transfer.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: hdl/aigh_dpath.sv
// Datapath for the AIG structural hashing unit: constant folding, key
// ordering, hashing, the probed gate table, counters and result registers.
// Depends on aigh_pkg and aigh_ram.
module aigh_dpath #(
  parameter int LIT_BITS    = aigh_pkg::LIT_BITS_DEF,
  parameter int TABLE_DEPTH = aigh_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_opcode,
  input  logic [LIT_BITS-1:0]            in_lit_a,
  input  logic [LIT_BITS-1:0]            in_lit_b,
  output logic [LIT_BITS-1:0]            out_result_literal,
  output logic [aigh_pkg::OUTCOME_W-1:0] out_outcome,
  input  aigh_pkg::cmd_t                 cmd,
  output aigh_pkg::status_t              sts
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W = 2 * LIT_BITS;
  localparam int ROW_W = 1 + KEY_W + LIT_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_WIDE = (IDX_W + 1)'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(TABLE_DEPTH);
  localparam logic [LIT_BITS-1:0] ODD_MASK = aigh_pkg::LIT_ODD_CLEAR[LIT_BITS-1:0];
  localparam logic [LIT_BITS-1:0] LIT_ONE  = LIT_BITS'(1);

  logic [KEY_W-1:0]               key_r;
  logic [IDX_W-1:0]               idx_r;
  logic [IDX_W-1:0]               probe_cnt_r;
  logic [IDX_W-1:0]               clr_idx_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [LIT_BITS-1:0]            last_r;
  logic [LIT_BITS-1:0]            res_lit_r;
  logic [aigh_pkg::OUTCOME_W-1:0] res_code_r;
  logic [LIT_BITS-1:0]            out_lit_r;
  logic [aigh_pkg::OUTCOME_W-1:0] out_code_r;

  logic [LIT_BITS-1:0]            lo, hi;
  logic [KEY_W-1:0]               key_in;
  logic [IDX_W-1:0]               hash;
  logic [IDX_W:0]                 hash_wide;
  logic [IDX_W-1:0]               start_idx;
  logic                           fold_hit;
  logic [LIT_BITS-1:0]            fold_lit;
  logic [LIT_BITS:0]              next_sum;
  logic [LIT_BITS-1:0]            next_lit;
  logic                           room;
  logic                           alloc_ok;
  logic [LIT_BITS-1:0]            direct_lit;
  logic [aigh_pkg::OUTCOME_W-1:0] direct_code;

  logic                           ram_we;
  logic [IDX_W-1:0]               ram_addr;
  logic [ROW_W-1:0]               ram_wdata;
  logic [ROW_W-1:0]               ram_rdata;
  logic                           row_valid;
  logic [KEY_W-1:0]               row_key;
  logic [LIT_BITS-1:0]            row_lit;

  // Next literal; last_r is always even, so a carry out means no room.
  assign next_sum = {1'b0, last_r} + (LIT_BITS + 1)'(2);
  assign next_lit = next_sum[LIT_BITS-1:0];
  assign room     = !next_sum[LIT_BITS];
  assign alloc_ok = room && (cnt_r < DEPTH_CNT);

  // Constant folding, in priority order.
  always_comb begin
    fold_hit = 1'b1;
    fold_lit = '0;
    if (in_lit_a == '0 || in_lit_b == '0) begin
      fold_lit = '0;
    end else if (in_lit_a == LIT_ONE) begin
      fold_lit = in_lit_b;
    end else if (in_lit_b == LIT_ONE) begin
      fold_lit = in_lit_a;
    end else if (in_lit_a == in_lit_b) begin
      fold_lit = in_lit_a;
    end else if ((in_lit_a & ODD_MASK) == (in_lit_b & ODD_MASK)) begin
      fold_lit = '0;
    end else begin
      fold_hit = 1'b0;
    end
  end

  // Result of a request that needs no lookup.
  always_comb begin
    if (in_opcode) begin
      direct_lit  = room ? next_lit : '0;
      direct_code = room ? aigh_pkg::OUT_NEW_INPUT : aigh_pkg::OUT_FULL;
    end else begin
      direct_lit  = fold_lit;
      direct_code = aigh_pkg::OUT_FOLDED;
    end
  end

  // Ordered key: the lower literal sits in the upper half.
  assign lo     = (in_lit_a < in_lit_b) ? in_lit_a : in_lit_b;
  assign hi     = (in_lit_a < in_lit_b) ? in_lit_b : in_lit_a;
  assign key_in = {lo, hi};

  // XOR fold of the key down to an index, then one wrap into the table.
  always_comb begin
    int j;
    hash = '0;
    j    = 0;
    for (int k = 0; k < KEY_W; k++) begin
      hash[j] = hash[j] ^ key_in[k];
      if (j == IDX_W - 1) begin
        j = 0;
      end else begin
        j = j + 1;
      end
    end
    hash_wide = {1'b0, hash};
    if (hash_wide >= DEPTH_WIDE) begin
      hash_wide = hash_wide - DEPTH_WIDE;
    end
    start_idx = hash_wide[IDX_W-1:0];
  end

  // Gate table rows: valid flag, key and literal.
  assign row_valid = ram_rdata[ROW_W-1];
  assign row_key   = ram_rdata[ROW_W-2:LIT_BITS];
  assign row_lit   = ram_rdata[LIT_BITS-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx_r;
    ram_wdata = {1'b1, key_r, next_lit};
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_addr  = clr_idx_r;
      ram_wdata = '0;
    end else if (cmd.take_miss && alloc_ok) begin
      ram_we = 1'b1;
    end
  end

  aigh_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Counters that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      cnt_r     <= '0;
      last_r    <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
      if (cmd.take && in_opcode && room) begin
        last_r <= next_lit;
      end
      if (cmd.take_miss && alloc_ok) begin
        last_r <= next_lit;
        cnt_r  <= cnt_r + CNT_W'(1);
      end
    end
  end

  // Request, probe and result registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      key_r       <= key_in;
      idx_r       <= start_idx;
      probe_cnt_r <= '0;
      res_lit_r   <= direct_lit;
      res_code_r  <= direct_code;
    end
    if (cmd.step) begin
      idx_r       <= (idx_r == LAST_IDX) ? '0 : idx_r + IDX_W'(1);
      probe_cnt_r <= probe_cnt_r + IDX_W'(1);
    end
    if (cmd.take_hit) begin
      res_lit_r  <= row_lit;
      res_code_r <= aigh_pkg::OUT_FOUND;
    end
    if (cmd.take_miss) begin
      res_lit_r  <= alloc_ok ? next_lit : '0;
      res_code_r <= alloc_ok ? aigh_pkg::OUT_NEW_GATE : aigh_pkg::OUT_FULL;
    end
    if (cmd.emit) begin
      out_lit_r  <= res_lit_r;
      out_code_r <= res_code_r;
    end
  end

  // Status towards the controller.
  assign sts.clr_done   = (clr_idx_r == LAST_IDX);
  assign sts.direct     = in_opcode || fold_hit;
  assign sts.hit        = row_valid && (row_key == key_r);
  assign sts.empty      = !row_valid;
  assign sts.probe_last = (probe_cnt_r == LAST_IDX);

  assign out_result_literal = out_lit_r;
  assign out_outcome        = out_code_r;

endmodule
